### sv/srrb_pkg.sv
// Shared types and constants for the selective repeat reorder buffer.
// No dependencies; imported by every module of the block.
`default_nettype none
package srrb_pkg;

	localparam int SEQ_W             = 16;
	localparam int DATA_W            = 32;
	localparam int WINDOW_DEF        = 8;
	localparam int PAYLOAD_WIDTH_DEF = 32;
	localparam int FIFO_DEPTH        = 4;

	typedef struct packed {
		logic [SEQ_W-1:0]  seq;
		logic [DATA_W-1:0] pay;
		logic              last;
	} item_t;

	typedef struct packed {
		logic              strobe;
		logic [DATA_W-1:0] pay;
		logic [SEQ_W-1:0]  seq;
		logic              eos;
		logic              evicted;
		logic              last_run;
	} result_t;

	typedef struct packed {
		logic full;
		logic room;
	} fifo_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_FIRST,
		ST_DRAIN
	} back_state_t;

endpackage
`default_nettype wire

### sv/srrb_front.sv
// Front stage: takes input transfers and works out the slot index seq mod WINDOW.
// Depends on srrb_pkg; feeds srrb_fifo.
`default_nettype none
module srrb_front #(
	parameter int WINDOW        = srrb_pkg::WINDOW_DEF,
	parameter int PAYLOAD_WIDTH = srrb_pkg::PAYLOAD_WIDTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [srrb_pkg::SEQ_W-1:0] seq_no,
	input  wire logic [srrb_pkg::DATA_W-1:0] payload,
	input  wire logic                       last_flag,
	output logic                            busy,
	input  wire logic                       room,
	output logic                            push,
	output srrb_pkg::item_t                 push_item,
	output logic [$clog2(WINDOW)-1:0]       push_idx
);
	import srrb_pkg::*;

	localparam int IDX_W = $clog2(WINDOW);
	localparam int SW    = (PAYLOAD_WIDTH < DATA_W) ? PAYLOAD_WIDTH : DATA_W;
	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / WINDOW);

	logic        accept;
	logic        s1_valid_q;
	item_t       item_s1;
	logic [47:0] prod_s1;
	logic [15:0] quo;
	logic [16:0] qw;
	logic [16:0] rem_raw;
	logic [16:0] rem;

	assign busy   = s1_valid_q || !room;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.seq  <= seq_no;
			item_s1.pay  <= DATA_W'(payload[SW-1:0]);
			item_s1.last <= last_flag;
			prod_s1      <= 48'(seq_no) * 48'(RECIP);
		end
	end

	// reciprocal estimate is low by at most one, one correction step
	always_comb begin
		quo     = prod_s1[47:32];
		qw      = 17'(32'(quo) * 32'(WINDOW));
		rem_raw = {1'b0, item_s1.seq} - qw;
		rem     = (rem_raw >= 17'(WINDOW)) ? rem_raw - 17'(WINDOW) : rem_raw;
	end

	assign push      = s1_valid_q;
	assign push_item = item_s1;
	assign push_idx  = rem[IDX_W-1:0];

endmodule
`default_nettype wire

### sv/srrb_fifo.sv
// Short queue between the front stage and the back sequencer.
// Depends on srrb_pkg for the status struct.
`default_nettype none
module srrb_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = srrb_pkg::FIFO_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty,
	output srrb_pkg::fifo_stat_t  stat
);
	import srrb_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	assign rdata     = mem_q[rd_ptr_q];
	assign empty     = (cnt_q == '0);
	assign stat.full = (cnt_q == CW'(DEPTH));
	// room for one more transfer on top of the one the front may hold
	assign stat.room = (cnt_q <= CW'(DEPTH - 2));

endmodule
`default_nettype wire

### sv/srrb_back.sv
// Back sequencer: slot memory, valid bits, head pointer, eviction and in-order drain.
// Depends on srrb_pkg; pops from srrb_fifo.
`default_nettype none
module srrb_back #(
	parameter int WINDOW        = srrb_pkg::WINDOW_DEF,
	parameter int PAYLOAD_WIDTH = srrb_pkg::PAYLOAD_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        empty,
	input  wire srrb_pkg::item_t             fifo_item,
	input  wire logic [$clog2(WINDOW)-1:0]   fifo_idx,
	output logic                             pop,
	output srrb_pkg::result_t                res
);
	import srrb_pkg::*;

	localparam int IDX_W = $clog2(WINDOW);
	localparam int SW    = (PAYLOAD_WIDTH < DATA_W) ? PAYLOAD_WIDTH : DATA_W;

	back_state_t st_q, st_d;

	logic [SEQ_W-1:0] mem_seq  [WINDOW];
	logic [SW-1:0]    mem_pay  [WINDOW];
	logic             mem_last [WINDOW];

	logic [SEQ_W-1:0] rd_seq_q;
	logic [SW-1:0]    rd_pay_q;
	logic             rd_last_q;

	logic [WINDOW-1:0] valid_q;
	logic [IDX_W-1:0]  head_q;
	logic [IDX_W-1:0]  head_nx;
	item_t             cur_q;
	logic [IDX_W-1:0]  cur_idx_q;

	logic [IDX_W-1:0]  rd_addr;
	logic              wr_en;
	logic              clr_head;
	logic              adv_head;
	logic              hit;
	logic              dup;
	logic              at_head;
	logic              more;

	logic              strobe_q;
	logic              emit;
	result_t           out_d;
	result_t           out_q;

	assign head_nx = (head_q == IDX_W'(WINDOW - 1)) ? '0 : head_q + 1'b1;
	assign hit     = valid_q[cur_idx_q];
	assign dup     = hit && (rd_seq_q >= cur_q.seq);
	assign at_head = (cur_idx_q == head_q);
	assign more    = valid_q[head_nx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d     = st_q;
		pop      = 1'b0;
		rd_addr  = fifo_idx;
		wr_en    = 1'b0;
		clr_head = 1'b0;
		adv_head = 1'b0;
		emit     = 1'b0;
		out_d    = '0;
		case (st_q)
			ST_IDLE: begin
				if (!empty) begin
					pop  = 1'b1;
					st_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (dup) begin
					st_d = ST_IDLE;
				end else if (hit) begin
					emit             = 1'b1;
					out_d.pay        = DATA_W'(rd_pay_q);
					out_d.seq        = rd_seq_q;
					out_d.evicted    = 1'b1;
					out_d.last_run   = !at_head;
					if (at_head) begin
						clr_head = 1'b1;
						st_d     = ST_FIRST;
					end else begin
						wr_en = 1'b1;
						st_d  = ST_IDLE;
					end
				end else if (at_head) begin
					// new packet lands on the head: deliver it straight away
					emit           = 1'b1;
					out_d.pay      = cur_q.pay;
					out_d.seq      = cur_q.seq;
					out_d.eos      = cur_q.last;
					out_d.last_run = !more;
					adv_head       = 1'b1;
					rd_addr        = head_nx;
					st_d           = more ? ST_DRAIN : ST_IDLE;
				end else begin
					wr_en = 1'b1;
					st_d  = ST_IDLE;
				end
			end
			ST_FIRST: begin
				emit           = 1'b1;
				out_d.pay      = cur_q.pay;
				out_d.seq      = cur_q.seq;
				out_d.eos      = cur_q.last;
				out_d.last_run = !more;
				adv_head       = 1'b1;
				rd_addr        = head_nx;
				st_d           = more ? ST_DRAIN : ST_IDLE;
			end
			ST_DRAIN: begin
				emit           = 1'b1;
				out_d.pay      = DATA_W'(rd_pay_q);
				out_d.seq      = rd_seq_q;
				out_d.eos      = rd_last_q;
				out_d.last_run = !more;
				clr_head       = 1'b1;
				adv_head       = 1'b1;
				rd_addr        = head_nx;
				st_d           = more ? ST_DRAIN : ST_IDLE;
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			head_q   <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit;
			if (wr_en) begin
				valid_q[cur_idx_q] <= 1'b1;
			end
			if (clr_head) begin
				valid_q[head_q] <= 1'b0;
			end
			if (adv_head) begin
				head_q <= head_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q     <= fifo_item;
			cur_idx_q <= fifo_idx;
		end
		if (wr_en) begin
			mem_seq[cur_idx_q]  <= cur_q.seq;
			mem_pay[cur_idx_q]  <= cur_q.pay[SW-1:0];
			mem_last[cur_idx_q] <= cur_q.last;
		end
		rd_seq_q  <= mem_seq[rd_addr];
		rd_pay_q  <= mem_pay[rd_addr];
		rd_last_q <= mem_last[rd_addr];
		if (emit) begin
			out_q <= out_d;
		end
	end

	always_comb begin
		res        = out_q;
		res.strobe = strobe_q;
	end

endmodule
`default_nettype wire

### sv/selective_repeat_reorder_buffer.sv
// Top level of the selective repeat reorder buffer.
// Depends on srrb_pkg, srrb_front, srrb_fifo and srrb_back.
//
// A packet transfers when start is high and busy is low; busy rises for the cycle after
// every transfer, and also while the four-entry queue is nearly full. Results leave on
// the result ports for one cycle each, flagged by result_strobe, and cannot be held off.
// The back sequencer handles each packet in two steps (queue pop, then slot memory read
// and compare) and pops no new packet until it has emitted its results; a drain runs one
// delivery per cycle from the slot memory. On the way in, a packet passes the front
// stage register, the queue and the current-packet register; results are registered.
`default_nettype none
module selective_repeat_reorder_buffer #(
	parameter int WINDOW        = srrb_pkg::WINDOW_DEF,
	parameter int PAYLOAD_WIDTH = srrb_pkg::PAYLOAD_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [srrb_pkg::SEQ_W-1:0]  seq_no,
	input  wire logic [srrb_pkg::DATA_W-1:0] payload,
	input  wire logic                        last_flag,
	output logic                             busy,
	output logic                             result_strobe,
	output logic [srrb_pkg::DATA_W-1:0]      out_payload,
	output logic [srrb_pkg::SEQ_W-1:0]       out_seq_no,
	output logic                             end_of_stream,
	output logic                             evicted,
	output logic                             last_of_run
);
	import srrb_pkg::*;

	localparam int IDX_W  = $clog2(WINDOW);
	localparam int QW     = $bits(item_t) + IDX_W;

	logic             push;
	item_t            push_item;
	logic [IDX_W-1:0] push_idx;
	fifo_stat_t       fstat;
	logic             pop;
	logic             empty;
	logic [QW-1:0]    q_rdata;
	item_t            fifo_item;
	logic [IDX_W-1:0] fifo_idx;
	result_t          res;

	srrb_front #(
		.WINDOW        (WINDOW),
		.PAYLOAD_WIDTH (PAYLOAD_WIDTH)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.seq_no         (seq_no),
		.payload        (payload),
		.last_flag      (last_flag),
		.busy           (busy),
		.room           (fstat.room),
		.push           (push),
		.push_item      (push_item),
		.push_idx       (push_idx)
	);

	srrb_fifo #(
		.WIDTH (QW),
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({push_idx, push_item}),
		.pop    (pop),
		.rdata  (q_rdata),
		.empty  (empty),
		.stat   (fstat)
	);

	assign fifo_item = q_rdata[$bits(item_t)-1:0];
	assign fifo_idx  = q_rdata[QW-1:$bits(item_t)];

	srrb_back #(
		.WINDOW        (WINDOW),
		.PAYLOAD_WIDTH (PAYLOAD_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.fifo_item (fifo_item),
		.fifo_idx  (fifo_idx),
		.pop       (pop),
		.res       (res)
	);

	assign result_strobe = res.strobe;
	assign out_payload   = res.pay;
	assign out_seq_no    = res.seq;
	assign end_of_stream = res.eos;
	assign evicted       = res.evicted;
	assign last_of_run   = res.last_run;

	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after input transfer");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !fstat.full)
		else $error("queue push while full");

	a_evict_no_eos: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && evicted |-> !end_of_stream)
		else $error("evicted result flagged end of stream");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue pop while empty");

endmodule
`default_nettype wire

### bench/selective_repeat_reorder_buffer_tb.sv
// Testbench for selective_repeat_reorder_buffer: a directed packet table, then random
// packet streams under three sender idle profiles, checked against an in-bench reorder model.
// Depends on srrb_pkg and the block's RTL; needs nothing else.
`timescale 1ns / 100ps
module selective_repeat_reorder_buffer_tb;
	import srrb_pkg::*;

	localparam int WIN             = WINDOW_DEF;
	localparam int ITEMS_PER_PHASE = 33;
	localparam int SETTLE_PAD      = 24;
	localparam int QUIET_LIMIT     = 2000;
	localparam int MAX_SHOWN       = 50;

	typedef struct packed {
		logic [DATA_W-1:0] pay;
		logic [SEQ_W-1:0]  seq;
		logic              eos;
		logic              evi;
		logic              lor;
	} delivery_t;

	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_NONE,
		CHK_ONE
	} row_chk_t;

	typedef struct packed {
		logic [SEQ_W-1:0]  seq;
		logic [DATA_W-1:0] pay;
		logic              last;
		row_chk_t          chk;
		delivery_t         exp;
	} table_row_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic [SEQ_W-1:0]  seq_no;
	logic [DATA_W-1:0] payload;
	logic              last_flag;
	logic              busy;
	logic              result_strobe;
	logic [DATA_W-1:0] out_payload;
	logic [SEQ_W-1:0]  out_seq_no;
	logic              end_of_stream;
	logic              evicted;
	logic              last_of_run;

	// model of the slot memory
	logic              slot_ok [WIN];
	logic [SEQ_W-1:0]  slot_sn [WIN];
	logic [DATA_W-1:0] slot_pw [WIN];
	logic              slot_lf [WIN];
	int                head_slot;

	delivery_t  step_out[$];
	delivery_t  pending_deliveries[$];
	table_row_t plan[$];

	row_chk_t  row_chk;
	delivery_t row_exp;
	int        idle_pct;
	int        backlog;
	int        quiet_cycles;
	int        mismatches;
	int        sent_cnt;
	int        n_dropped;
	int        n_results;
	int        n_evict;
	int        n_eos;
	int        max_burst;

	selective_repeat_reorder_buffer dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.seq_no         (seq_no),
		.payload        (payload),
		.last_flag      (last_flag),
		.busy           (busy),
		.result_strobe  (result_strobe),
		.out_payload    (out_payload),
		.out_seq_no     (out_seq_no),
		.end_of_stream  (end_of_stream),
		.evicted        (evicted),
		.last_of_run    (last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic delivery_t delivery(input logic [DATA_W-1:0] p, input logic [SEQ_W-1:0] s,
			input logic eos, input logic evi, input logic lor);
		delivery_t d;
		d.pay = p;
		d.seq = s;
		d.eos = eos;
		d.evi = evi;
		d.lor = lor;
		return d;
	endfunction

	function automatic table_row_t trow(input logic [SEQ_W-1:0] s, input logic [DATA_W-1:0] p,
			input logic l, input row_chk_t c, input delivery_t e);
		table_row_t t;
		t.seq  = s;
		t.pay  = p;
		t.last = l;
		t.chk  = c;
		t.exp  = e;
		return t;
	endfunction

	task report_mismatch(input string what);
		begin
			mismatches++;
			if (mismatches <= MAX_SHOWN)
				$display("%0t MISMATCH %s", $time, what);
		end
	endtask

	// Slot update for one packet; the results it causes land in step_out.
	task reorder_predict(input logic [SEQ_W-1:0] s, input logic [DATA_W-1:0] p, input logic l,
			output bit kept);
		int idx;
		int g;
		begin
			step_out.delete();
			idx  = s % WIN;
			kept = !(slot_ok[idx] && slot_sn[idx] >= s);
			if (kept) begin
				if (slot_ok[idx])
					step_out.push_back(delivery(slot_pw[idx], slot_sn[idx], 1'b0, 1'b1, 1'b0));
				slot_ok[idx] = 1'b1;
				slot_sn[idx] = s;
				slot_pw[idx] = p;
				slot_lf[idx] = l;
				if (idx == head_slot) begin
					for (g = 0; g < WIN && slot_ok[head_slot]; g++) begin
						step_out.push_back(delivery(slot_pw[head_slot], slot_sn[head_slot],
							slot_lf[head_slot], 1'b0, 1'b0));
						slot_ok[head_slot] = 1'b0;
						head_slot = (head_slot + 1) % WIN;
					end
				end
				if (step_out.size() > 0)
					step_out[step_out.size() - 1].lor = 1'b1;
			end
		end
	endtask

	always @(posedge clk) begin : monitor
		delivery_t want;
		delivery_t got;
		bit        kept;
		bit        moved;
		if (arst_n) begin
			moved = 1'b0;
			if (result_strobe) begin
				moved = 1'b1;
				got = delivery(out_payload, out_seq_no, end_of_stream, evicted, last_of_run);
				n_results++;
				if (evicted)
					n_evict++;
				if (end_of_stream)
					n_eos++;
				if (pending_deliveries.size() == 0) begin
					report_mismatch($sformatf("unexpected result seq %0d payload %h",
						got.seq, got.pay));
				end else begin
					want = pending_deliveries.pop_front();
					if (got.pay !== want.pay)
						report_mismatch($sformatf("out_payload %h, want %h (seq %0d)",
							got.pay, want.pay, want.seq));
					if (got.seq !== want.seq)
						report_mismatch($sformatf("out_seq_no %0d, want %0d",
							got.seq, want.seq));
					if (got.eos !== want.eos)
						report_mismatch($sformatf("end_of_stream %b, want %b (seq %0d)",
							got.eos, want.eos, want.seq));
					if (got.evi !== want.evi)
						report_mismatch($sformatf("evicted %b, want %b (seq %0d)",
							got.evi, want.evi, want.seq));
					if (got.lor !== want.lor)
						report_mismatch($sformatf("last_of_run %b, want %b (seq %0d)",
							got.lor, want.lor, want.seq));
				end
			end
			if (start && !busy) begin
				moved = 1'b1;
				reorder_predict(seq_no, payload, last_flag, kept);
				if (!kept)
					n_dropped++;
				if (step_out.size() > max_burst)
					max_burst = step_out.size();
				case (row_chk)
					CHK_MODEL: begin
						foreach (step_out[i])
							pending_deliveries.push_back(step_out[i]);
					end
					CHK_ONE: begin
						pending_deliveries.push_back(row_exp);
					end
					default: ;
				endcase
			end
			backlog      <= pending_deliveries.size();
			quiet_cycles <= moved ? 0 : quiet_cycles + 1;
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("Mismatches found");
		$finish;
	end

	task offer_packet(input logic [SEQ_W-1:0] s, input logic [DATA_W-1:0] p, input logic l,
			input row_chk_t c, input delivery_t e);
		begin
			if ($urandom_range(99) < idle_pct) begin
				start <= 1'b0;
				do
					@(posedge clk);
				while ($urandom_range(99) < idle_pct);
			end
			start     <= 1'b1;
			seq_no    <= s;
			payload   <= p;
			last_flag <= l;
			row_chk   <= c;
			row_exp   <= e;
			@(posedge clk);
			while (busy)
				@(posedge clk);
			sent_cnt++;
		end
	endtask

	// sender holds off until every expected result is in, then lets the pipe empty
	task wait_drained;
		begin
			start <= 1'b0;
			@(posedge clk);
			while (backlog != 0)
				@(posedge clk);
			repeat (SETTLE_PAD)
				@(posedge clk);
		end
	endtask

	initial begin : stimulus
		int               ph;
		int               r;
		int               k;
		int               goal;
		logic [SEQ_W-1:0] s;
		logic [SEQ_W-1:0] base;
		logic [WIN-1:0]   ahead;
		arst_n         = 1'b0;
		start          = 1'b0;
		seq_no         = '0;
		payload        = '0;
		last_flag      = 1'b0;
		row_chk        = CHK_MODEL;
		row_exp        = '0;
		idle_pct       = 25;
		backlog        = 0;
		quiet_cycles   = 0;
		mismatches     = 0;
		sent_cnt       = 0;
		n_dropped      = 0;
		n_results      = 0;
		n_evict        = 0;
		n_eos          = 0;
		max_burst      = 0;
		head_slot      = 0;
		for (k = 0; k < WIN; k++) begin
			slot_ok[k] = 1'b0;
			slot_sn[k] = '0;
			slot_pw[k] = '0;
			slot_lf[k] = 1'b0;
		end

		plan.push_back(trow(16'd0, 32'h0000_0000, 1'b0, CHK_ONE,
			delivery(32'h0000_0000, 16'd0, 1'b0, 1'b0, 1'b1)));
		plan.push_back(trow(16'd0, 32'h1234_5678, 1'b0, CHK_NONE, '0));
		// duplicate of a stored packet
		plan.push_back(trow(16'd0, 32'hDEAD_BEEF, 1'b1, CHK_NONE, '0));
		plan.push_back(trow(16'd1, 32'hFFFF_FFFF, 1'b1, CHK_ONE,
			delivery(32'hFFFF_FFFF, 16'd1, 1'b1, 1'b0, 1'b1)));
		plan.push_back(trow(16'd9, 32'hA5A5_A5A5, 1'b0, CHK_MODEL, '0));
		plan.push_back(trow(16'd3, 32'hC0DE_0003, 1'b0, CHK_MODEL, '0));
		plan.push_back(trow(16'd4, 32'hC0DE_0004, 1'b0, CHK_MODEL, '0));
		plan.push_back(trow(16'd5, 32'hC0DE_0005, 1'b0, CHK_MODEL, '0));
		plan.push_back(trow(16'd6, 32'hC0DE_0006, 1'b0, CHK_MODEL, '0));
		plan.push_back(trow(16'd7, 32'h0000_0007, 1'b1, CHK_MODEL, '0));
		// eviction of a last-flagged packet: no end of stream
		plan.push_back(trow(16'd65535, 32'h8000_0001, 1'b0, CHK_ONE,
			delivery(32'h0000_0007, 16'd7, 1'b0, 1'b1, 1'b1)));
		// head fill drains the whole window
		plan.push_back(trow(16'd2, 32'h0000_0002, 1'b0, CHK_MODEL, '0));
		plan.push_back(trow(16'd100, 32'h0000_0064, 1'b0, CHK_MODEL, '0));
		plan.push_back(trow(16'd92, 32'h5555_5555, 1'b0, CHK_NONE, '0));
		plan.push_back(trow(16'd100, 32'hAAAA_AAAA, 1'b1, CHK_NONE, '0));
		plan.push_back(trow(16'd65535, 32'h0F0F_0F0F, 1'b1, CHK_MODEL, '0));
		plan.push_back(trow(16'd65534, 32'hF0F0_F0F0, 1'b0, CHK_MODEL, '0));
		plan.push_back(trow(16'd2, 32'h7FFF_FFFF, 1'b0, CHK_MODEL, '0));
		plan.push_back(trow(16'd65531, 32'h0000_0001, 1'b0, CHK_MODEL, '0));
		plan.push_back(trow(16'd13, 32'h3333_CCCC, 1'b0, CHK_MODEL, '0));

		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			offer_packet(plan[i].seq, plan[i].pay, plan[i].last, plan[i].chk, plan[i].exp);
		wait_drained();

		// streams stay aligned with the head slot so in-order drains keep happening
		base  = {13'($urandom), 3'(head_slot)};
		ahead = '0;
		for (ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 25 : (ph == 1) ? 80 : 0;
			goal     = sent_cnt + ITEMS_PER_PHASE;
			while (sent_cnt < goal) begin
				r = $urandom_range(99);
				if (r < 75) begin
					do
						k = $urandom_range(WIN - 1);
					while (ahead[k]);
					s        = base + SEQ_W'(k);
					ahead[k] = 1'b1;
					while (ahead[0]) begin
						ahead = ahead >> 1;
						base  = base + 1'b1;
					end
				end else if (r < 87) begin
					s = base - SEQ_W'($urandom_range(1, WIN));
				end else if (r < 96) begin
					s = base + SEQ_W'(WIN + $urandom_range(WIN - 1));
				end else begin
					s     = SEQ_W'($urandom);
					base  = {13'($urandom), base[2:0]};
					ahead = '0;
				end
				offer_packet(s, $urandom, $urandom_range(15) == 0, CHK_MODEL, '0);
			end
			wait_drained();
		end

		if (backlog != 0)
			report_mismatch($sformatf("%0d expected results never arrived", backlog));
		$display("Run covered %0d packets (%0d dropped as duplicate or stale), %0d results,",
			sent_cnt, n_dropped, n_results);
		$display("  %0d evictions, %0d end-of-stream marks, longest burst %0d.",
			n_evict, n_eos, max_burst);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
